[src/mbtcp_pkg.sv]
// Package for the Modbus/TCP request parser: transaction types, status codes,
// byte positions of the captured fields and frame length limits.
// No dependencies.
`default_nettype none

package mbtcp_pkg;

   localparam int unsigned POS_W = 17;
   localparam int unsigned SIZE_W = POS_W + 1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] txn_id;
      logic [7:0]  unit_id;
      logic [7:0]  func_code;
      logic [15:0] start_addr;
      logic [15:0] request_value;
   } rsp_type;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_SHORT       = 3'd1;
   localparam logic [2:0] ST_LEN_MISMATCH = 3'd2;
   localparam logic [2:0] ST_FC03_SHORT  = 3'd3;
   localparam logic [2:0] ST_FC06_SHORT  = 3'd4;
   localparam logic [2:0] ST_FC16_SHORT  = 3'd5;
   localparam logic [2:0] ST_FC16_DATA   = 3'd6;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_WRITE_SINGLE  = 8'd6;
   localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;

   localparam logic [POS_W-1:0] POS_TID_HI   = 17'd0;
   localparam logic [POS_W-1:0] POS_TID_LO   = 17'd1;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd4;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd5;
   localparam logic [POS_W-1:0] POS_UNIT     = 17'd6;
   localparam logic [POS_W-1:0] POS_FUNC     = 17'd7;
   localparam logic [POS_W-1:0] POS_ADDR_HI  = 17'd8;
   localparam logic [POS_W-1:0] POS_ADDR_LO  = 17'd9;
   localparam logic [POS_W-1:0] POS_WORD_HI  = 17'd10;
   localparam logic [POS_W-1:0] POS_WORD_LO  = 17'd11;
   localparam logic [POS_W-1:0] POS_COUNT    = 17'd12;
   localparam logic [POS_W-1:0] POS_VALUE_HI = 17'd13;
   localparam logic [POS_W-1:0] POS_VALUE_LO = 17'd14;
   localparam logic [POS_W-1:0] POS_MAX      = 17'd131071;

   localparam logic [SIZE_W-1:0] MIN_FRAME      = 18'd8;
   localparam logic [SIZE_W-1:0] MBAP_FIXED     = 18'd6;
   localparam logic [SIZE_W-1:0] MIN_FC03_FC06  = 18'd12;
   localparam logic [SIZE_W-1:0] MIN_FC16       = 18'd13;
   localparam logic [SIZE_W-1:0] MIN_FC16_VALUE = 18'd15;

endpackage

`default_nettype wire

[src/modbus_tcp_request_parser.sv]
// Modbus/TCP request parser top level: byte capture, verdict and result register.
// Depends on mbtcp_pkg.
`default_nettype none

// Takes one frame byte per cycle with no gaps needed between frames. Each byte
// updates the position counter and the captured MBAP and request fields; on
// the byte marked frame_end the verdict is formed from the captured fields in
// the same cycle and appears in the result register on the next cycle, after
// which the parser state is back at frame start. Throughput is one byte per
// cycle, set by the single capture/verdict register stage; the input stalls
// only while a result waits in the result register and the result side stalls.
module modbus_tcp_request_parser (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  mbtcp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output mbtcp_pkg::rsp_type rsp_data
);

   logic [mbtcp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0] tid_ff, tid_in;
   logic [15:0] hlen_ff, hlen_in;
   logic [7:0]  unit_ff, unit_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] word_ff, word_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] value_ff, value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   mbtcp_pkg::rsp_type rsp_ff, rsp_in;

   logic accept;
   logic last;
   logic [mbtcp_pkg::SIZE_W-1:0] size;
   logic [mbtcp_pkg::SIZE_W-1:0] len_need;
   logic [mbtcp_pkg::SIZE_W-1:0] need16;
   logic [2:0]  status;
   logic [15:0] sel_value;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign last      = accept & req_data.frame_end;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      tid_in   = tid_ff;
      hlen_in  = hlen_ff;
      unit_in  = unit_ff;
      func_in  = func_ff;
      addr_in  = addr_ff;
      word_in  = word_ff;
      count_in = count_ff;
      value_in = value_ff;
      case (pos_ff)
         mbtcp_pkg::POS_TID_HI:   tid_in[15:8]   = req_data.data_byte;
         mbtcp_pkg::POS_TID_LO:   tid_in[7:0]    = req_data.data_byte;
         mbtcp_pkg::POS_LEN_HI:   hlen_in[15:8]  = req_data.data_byte;
         mbtcp_pkg::POS_LEN_LO:   hlen_in[7:0]   = req_data.data_byte;
         mbtcp_pkg::POS_UNIT:     unit_in        = req_data.data_byte;
         mbtcp_pkg::POS_FUNC:     func_in        = req_data.data_byte;
         mbtcp_pkg::POS_ADDR_HI:  addr_in[15:8]  = req_data.data_byte;
         mbtcp_pkg::POS_ADDR_LO:  addr_in[7:0]   = req_data.data_byte;
         mbtcp_pkg::POS_WORD_HI:  word_in[15:8]  = req_data.data_byte;
         mbtcp_pkg::POS_WORD_LO:  word_in[7:0]   = req_data.data_byte;
         mbtcp_pkg::POS_COUNT:    count_in       = req_data.data_byte;
         mbtcp_pkg::POS_VALUE_HI: value_in[15:8] = req_data.data_byte;
         mbtcp_pkg::POS_VALUE_LO: value_in[7:0]  = req_data.data_byte;
         default: ;
      endcase
   end

   always_comb begin
      if (pos_ff != mbtcp_pkg::POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end else begin
         pos_in = pos_ff;
      end
   end

   // verdict, using the fields as updated by the final byte
   always_comb begin
      size     = {1'b0, pos_ff} + 1'b1;
      len_need = mbtcp_pkg::MBAP_FIXED + {2'b00, hlen_in};
      need16   = mbtcp_pkg::MIN_FC16 + {10'd0, count_in};
      if (need16 < mbtcp_pkg::MIN_FC16_VALUE) begin
         need16 = mbtcp_pkg::MIN_FC16_VALUE;
      end
      sel_value = 16'd0;
      if (size < mbtcp_pkg::MIN_FRAME) begin
         status = mbtcp_pkg::ST_SHORT;
      end else if (size < len_need) begin
         status = mbtcp_pkg::ST_LEN_MISMATCH;
      end else if (func_in == mbtcp_pkg::FC_READ_HOLDING) begin
         status    = (size < mbtcp_pkg::MIN_FC03_FC06) ? mbtcp_pkg::ST_FC03_SHORT
                                                      : mbtcp_pkg::ST_OK;
         sel_value = word_in;
      end else if (func_in == mbtcp_pkg::FC_WRITE_SINGLE) begin
         status    = (size < mbtcp_pkg::MIN_FC03_FC06) ? mbtcp_pkg::ST_FC06_SHORT
                                                      : mbtcp_pkg::ST_OK;
         sel_value = word_in;
      end else if (func_in == mbtcp_pkg::FC_WRITE_MULTIPLE) begin
         if (size < mbtcp_pkg::MIN_FC16) begin
            status = mbtcp_pkg::ST_FC16_SHORT;
         end else if (size < need16) begin
            status = mbtcp_pkg::ST_FC16_DATA;
         end else begin
            status = mbtcp_pkg::ST_OK;
         end
         sel_value = value_in;
      end else begin
         status = mbtcp_pkg::ST_UNSUPPORTED;
      end

      rsp_in.status = status;
      if (status == mbtcp_pkg::ST_SHORT) begin
         rsp_in.txn_id    = 16'd0;
         rsp_in.unit_id   = 8'd0;
         rsp_in.func_code = 8'd0;
      end else begin
         rsp_in.txn_id    = tid_in;
         rsp_in.unit_id   = unit_in;
         rsp_in.func_code = func_in;
      end
      if (status == mbtcp_pkg::ST_OK) begin
         rsp_in.start_addr    = addr_in;
         rsp_in.request_value = sel_value;
      end else begin
         rsp_in.start_addr    = 16'd0;
         rsp_in.request_value = 16'd0;
      end
   end

   always_comb begin
      if (last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (last) begin
            pos_ff <= '0;
         end else if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tid_ff   <= tid_in;
         hlen_ff  <= hlen_in;
         unit_ff  <= unit_in;
         func_ff  <= func_in;
         addr_ff  <= addr_in;
         word_ff  <= word_in;
         count_ff <= count_in;
         value_ff <= value_in;
      end
      if (last) begin
         rsp_ff <= rsp_in;
      end
   end

   a_stall_only_when_holding : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

   a_frame_end_result : assert property (@(posedge clock) disable iff (reset)
      last |=> rsp_valid_ff && pos_ff == '0)
      else $error("frame end did not load a result or restart the frame");

   a_pos_advance : assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.frame_end && pos_ff != mbtcp_pkg::POS_MAX
      |=> pos_ff == $past(pos_ff) + 1'b1)
      else $error("byte position did not advance");

   a_short_clears_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == mbtcp_pkg::ST_SHORT
      |-> rsp_ff.txn_id == 16'd0 && rsp_ff.unit_id == 8'd0
          && rsp_ff.func_code == 8'd0)
      else $error("short frame result carries field data");

   a_reject_clears_request : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != mbtcp_pkg::ST_OK
      |-> rsp_ff.start_addr == 16'd0 && rsp_ff.request_value == 16'd0)
      else $error("rejected frame result carries request fields");

endmodule

`default_nettype wire

[verif/tb_modbus_tcp_request_parser.sv]
// Testbench for modbus_tcp_request_parser: sends Modbus/TCP frames byte by byte and
// checks each verdict against a behavioural model of the parser held in this file.
// Depends on mbtcp_pkg and the parser RTL.
`default_nettype none

module tb_modbus_tcp_request_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 16;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_mode_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   mbtcp_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   mbtcp_pkg::rsp_type rsp_data;

   // parser model state
   logic [mbtcp_pkg::POS_W-1:0] frame_pos = '0;
   logic [15:0]      cap_tid = '0;
   logic [15:0]      cap_len = '0;
   logic [7:0]       cap_unit = '0;
   logic [7:0]       cap_func = '0;
   logic [15:0]      cap_addr = '0;
   logic [15:0]      cap_word = '0;
   logic [7:0]       cap_count = '0;
   logic [15:0]      cap_first = '0;

   mbtcp_pkg::rsp_type expected_verdicts[$];
   logic [7:0]         frame_buf[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int bytes_sent = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   int hold_served = 0;
   int hold_requests = 0;

   modbus_tcp_request_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
      rsp_stall <= (hold_left > 1) || (hold_served != hold_requests) ||
                   ($urandom_range(0, 99) < rsp_stall_pct);
   end

   task automatic predict_byte(input mbtcp_pkg::req_type item);
      logic [mbtcp_pkg::POS_W-1:0]  pos;
      logic [mbtcp_pkg::SIZE_W-1:0] frame_size;
      logic [mbtcp_pkg::SIZE_W-1:0] fc16_need;
      logic [15:0]                  value_word;
      mbtcp_pkg::rsp_type           verdict;
      pos = frame_pos;
      value_word = '0;
      case (pos)
         mbtcp_pkg::POS_TID_HI:   cap_tid[15:8] = item.data_byte;
         mbtcp_pkg::POS_TID_LO:   cap_tid[7:0] = item.data_byte;
         mbtcp_pkg::POS_LEN_HI:   cap_len[15:8] = item.data_byte;
         mbtcp_pkg::POS_LEN_LO:   cap_len[7:0] = item.data_byte;
         mbtcp_pkg::POS_UNIT:     cap_unit = item.data_byte;
         mbtcp_pkg::POS_FUNC:     cap_func = item.data_byte;
         mbtcp_pkg::POS_ADDR_HI:  cap_addr[15:8] = item.data_byte;
         mbtcp_pkg::POS_ADDR_LO:  cap_addr[7:0] = item.data_byte;
         mbtcp_pkg::POS_WORD_HI:  cap_word[15:8] = item.data_byte;
         mbtcp_pkg::POS_WORD_LO:  cap_word[7:0] = item.data_byte;
         mbtcp_pkg::POS_COUNT:    cap_count = item.data_byte;
         mbtcp_pkg::POS_VALUE_HI: cap_first[15:8] = item.data_byte;
         mbtcp_pkg::POS_VALUE_LO: cap_first[7:0] = item.data_byte;
         default: ;
      endcase
      if (pos != mbtcp_pkg::POS_MAX) frame_pos = pos + 1'b1;
      if (item.frame_end) begin
         verdict = '0;
         frame_size = {1'b0, pos} + 1'b1;
         if (frame_size < mbtcp_pkg::MIN_FRAME) begin
            verdict.status = mbtcp_pkg::ST_SHORT;
         end else if (frame_size < mbtcp_pkg::MBAP_FIXED + {2'b00, cap_len}) begin
            verdict.status = mbtcp_pkg::ST_LEN_MISMATCH;
         end else if (cap_func == mbtcp_pkg::FC_READ_HOLDING) begin
            verdict.status = (frame_size < mbtcp_pkg::MIN_FC03_FC06) ?
                             mbtcp_pkg::ST_FC03_SHORT : mbtcp_pkg::ST_OK;
            value_word = cap_word;
         end else if (cap_func == mbtcp_pkg::FC_WRITE_SINGLE) begin
            verdict.status = (frame_size < mbtcp_pkg::MIN_FC03_FC06) ?
                             mbtcp_pkg::ST_FC06_SHORT : mbtcp_pkg::ST_OK;
            value_word = cap_word;
         end else if (cap_func == mbtcp_pkg::FC_WRITE_MULTIPLE) begin
            fc16_need = mbtcp_pkg::MIN_FC16 + {10'd0, cap_count};
            if (fc16_need < mbtcp_pkg::MIN_FC16_VALUE) fc16_need = mbtcp_pkg::MIN_FC16_VALUE;
            if (frame_size < mbtcp_pkg::MIN_FC16) verdict.status = mbtcp_pkg::ST_FC16_SHORT;
            else if (frame_size < fc16_need) verdict.status = mbtcp_pkg::ST_FC16_DATA;
            else verdict.status = mbtcp_pkg::ST_OK;
            value_word = cap_first;
         end else begin
            verdict.status = mbtcp_pkg::ST_UNSUPPORTED;
         end
         if (verdict.status != mbtcp_pkg::ST_SHORT) begin
            verdict.txn_id = cap_tid;
            verdict.unit_id = cap_unit;
            verdict.func_code = cap_func;
         end
         if (verdict.status == mbtcp_pkg::ST_OK) begin
            verdict.start_addr = cap_addr;
            verdict.request_value = value_word;
         end
         expected_verdicts = {expected_verdicts, verdict};
         frame_pos = '0;
         cap_tid = '0;
         cap_len = '0;
         cap_unit = '0;
         cap_func = '0;
         cap_addr = '0;
         cap_word = '0;
         cap_count = '0;
         cap_first = '0;
      end
   endtask

   always @(posedge clock) begin : check_verdicts
      mbtcp_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected transaction: status %0d tid %h", rsp_data.status,
                   rsp_data.txn_id);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.txn_id !== want.txn_id) begin
               $error("txn_id: expected %h, actual %h", want.txn_id, rsp_data.txn_id);
               fail_count++;
            end
            if (rsp_data.unit_id !== want.unit_id) begin
               $error("unit_id: expected %h, actual %h", want.unit_id, rsp_data.unit_id);
               fail_count++;
            end
            if (rsp_data.func_code !== want.func_code) begin
               $error("func_code: expected %h, actual %h", want.func_code,
                      rsp_data.func_code);
               fail_count++;
            end
            if (rsp_data.start_addr !== want.start_addr) begin
               $error("start_addr: expected %h, actual %h", want.start_addr,
                      rsp_data.start_addr);
               fail_count++;
            end
            if (rsp_data.request_value !== want.request_value) begin
               $error("request_value: expected %h, actual %h", want.request_value,
                      rsp_data.request_value);
               fail_count++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      mbtcp_pkg::req_type item;
      item.data_byte = data;
      item.frame_end = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_byte(item);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic build_frame(input int unsigned size, input logic [7:0] fc,
                              input logic [15:0] len_field, input logic [7:0] count,
                              input fill_mode_type fill);
      frame_buf.delete();
      for (int unsigned i = 0; i < size; i++) begin
         case (fill)
            FILL_ZERO: frame_buf = {frame_buf, 8'h00};
            FILL_ONES: frame_buf = {frame_buf, 8'hFF};
            default:   frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
         endcase
      end
      if (size > 5) begin
         frame_buf[4] = len_field[15:8];
         frame_buf[5] = len_field[7:0];
      end
      if (size > 7) frame_buf[7] = fc;
      if (size > 12) frame_buf[12] = count;
   endtask

   task automatic send_random_frame();
      int unsigned size;
      logic [7:0]  fc;
      logic [15:0] len_field;
      logic [7:0]  count;
      count = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 75) begin
         case ($urandom_range(0, 2))
            0: fc = mbtcp_pkg::FC_READ_HOLDING;
            1: fc = mbtcp_pkg::FC_WRITE_SINGLE;
            default: fc = mbtcp_pkg::FC_WRITE_MULTIPLE;
         endcase
         if (fc == mbtcp_pkg::FC_WRITE_MULTIPLE) begin
            count = 8'($urandom_range(0, 8));
            size = (count < 2) ? 15 : 13 + count;
            if ($urandom_range(0, 3) == 0) size = $urandom_range(8, 13 + count + 3);
         end else begin
            size = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 15) : 12;
         end
         len_field = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) :
                                                   16'(size - 6);
      end else begin
         size = $urandom_range(1, 20);
         fc = 8'($urandom_range(0, 255));
         len_field = $urandom_range(0, 1) ? 16'($urandom_range(0, 16)) :
                                            16'($urandom_range(0, 65535));
      end
      build_frame(size, fc, len_field, count, FILL_RANDOM);
      send_frame();
   endtask

   task automatic test_each_verdict();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      build_frame(1, 8'h00, 16'h0000, 8'h00, FILL_ONES);
      send_frame();
      build_frame(7, 8'h00, 16'hFFFF, 8'h00, FILL_ONES);
      send_frame();
      build_frame(8, mbtcp_pkg::FC_READ_HOLDING, 16'hFFFF, 8'h00, FILL_ONES);
      send_frame();
      build_frame(8, mbtcp_pkg::FC_READ_HOLDING, 16'h0002, 8'h00, FILL_ZERO);
      send_frame();
      build_frame(8, mbtcp_pkg::FC_WRITE_SINGLE, 16'h0000, 8'h00, FILL_ONES);
      send_frame();
      build_frame(12, mbtcp_pkg::FC_READ_HOLDING, 16'h0006, 8'hFF, FILL_ONES);
      send_frame();
      build_frame(12, mbtcp_pkg::FC_WRITE_SINGLE, 16'h0006, 8'h00, FILL_ZERO);
      send_frame();
      build_frame(12, mbtcp_pkg::FC_WRITE_MULTIPLE, 16'h0000, 8'h00, FILL_RANDOM);
      send_frame();
      // byte count of zero still needs the first value word
      build_frame(14, mbtcp_pkg::FC_WRITE_MULTIPLE, 16'h0008, 8'h00, FILL_RANDOM);
      send_frame();
      build_frame(20, mbtcp_pkg::FC_WRITE_MULTIPLE, 16'h000E, 8'hFF, FILL_ONES);
      send_frame();
      // trailing bytes past the first value word
      build_frame(18, mbtcp_pkg::FC_WRITE_MULTIPLE, 16'h0002, 8'h03, FILL_RANDOM);
      send_frame();
      build_frame(8, 8'h00, 16'h0002, 8'h00, FILL_RANDOM);
      send_frame();
      build_frame(9, 8'hFF, 16'h0000, 8'h00, FILL_ONES);
      send_frame();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int n_bytes);
      int target;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) send_random_frame();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_requests <= hold_requests + 1;
      repeat (6) send_random_frame();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_each_verdict();
      test_random_traffic(0, 0, 100);
      test_random_traffic(58, 0, 100);
      test_random_traffic(0, 58, 100);
      test_random_traffic(11, 11, 100);
      test_backpressure();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
